FILE: rtl/core/ctww_pkg.sv
// Shared types and constants for the console text wrap writer.
package ctww_pkg;

    // Character codes with special handling.
    localparam logic [7:0] C_NEWLINE = 8'h0A;
    localparam logic [7:0] C_TAB     = 8'h09;
    localparam logic [7:0] C_CR      = 8'h0D;
    localparam logic [7:0] C_SPACE   = 8'h20;
    localparam logic [7:0] C_ZERO    = 8'h00;

    // Tab stops fall on multiples of four columns.
    localparam int TAB_MASK = 3;

    // Controller states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_DECIDE,
        S_PREV,
        S_READ,
        S_WRAP_NL,
        S_PLACE,
        S_BLANKLINE,
        S_TAB,
        S_EOS,
        S_DONE
    } t_state;

    // Commands from controller to datapath.
    typedef struct packed {
        logic capture;      // latch input item
        logic clr_step;     // write one blank-zero cell during reset sweep
        logic prev_rd;      // read cell left of cursor
        logic cell_rd;      // read addressed cell for a read item
        logic hold_byte;    // append input byte to word buffer
        logic put_in;       // store input byte at cursor
        logic put_space;    // store a blank at cursor
        logic put_word;     // store next held byte at cursor
        logic new_line;     // advance line, column to zero
        logic blank_step;   // write one blank into the new line
        logic cr;           // column to zero
        logic set_result;   // load the output register
    } t_cmd;

    // Status from datapath to controller.
    typedef struct packed {
        logic clr_done;
        logic blank_done;
        logic mode;
        logic in_blank;     // input byte counts as blank
        logic is_nl;
        logic is_tab;
        logic is_cr;
        logic eos;
        logic prev_blank;   // cell left of cursor is blank
        logic col_zero;
        logic held_any;
        logic held_full;
        logic wrap_needed;  // held word must move to a new line first
        logic col_last;     // next put reaches line end
        logic tab_last;     // next blank reaches a tab stop
    } t_status;

endpackage

FILE: rtl/core/ctww_datapath.sv
// Datapath: line store, word buffer, cursor and result register.
module ctww_datapath #(
    parameter int LINE_CHARS = 40,
    parameter int LINES      = 25
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  ctww_pkg::t_cmd  i_cmd,
    output ctww_pkg::t_status o_sts,
    input  logic            i_mode,
    input  logic [7:0]      i_byte_in,
    input  logic            i_end_of_string,
    input  logic [4:0]      i_rows_back,
    input  logic [5:0]      i_read_column,
    output logic [7:0]      o_cell_byte,
    output logic [4:0]      o_line_now,
    output logic [5:0]      o_column_now,
    output logic [5:0]      o_held_bytes
);
    import ctww_pkg::*;

    localparam int DEPTH = LINES * LINE_CHARS;
    localparam int AW    = $clog2(DEPTH);
    localparam int LW    = $clog2(LINES);
    localparam int CW    = $clog2(LINE_CHARS);
    localparam int HW    = $clog2(LINE_CHARS + 1);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_word [LINE_CHARS];

    logic [LW-1:0] r_line, n_line;
    logic [CW-1:0] r_col, n_col;
    logic [HW-1:0] r_held, n_held;
    logic [HW-1:0] r_head, n_head;  // index of next held byte to place
    logic [CW-1:0] r_cnt;           // sweep column counter
    logic [AW-1:0] r_clr_addr;
    logic          r_clr_done;
    logic [7:0]    r_rdata;
    logic [7:0]    r_wdata;         // held byte at the head of the word buffer

    logic          r_mode, r_eos;
    logic [7:0]    r_byte;
    logic [LW-1:0] r_rd_line;
    logic [5:0]    r_rd_col;
    logic          r_rd_ok;

    logic [7:0] r_cell_byte;
    logic [4:0] r_line_out;
    logic [5:0] r_col_out, r_held_out;

    logic [AW-1:0] w_base;
    logic [AW-1:0] w_wr_addr, w_rd_addr;
    logic [7:0]    w_wr_data;
    logic          w_we;
    logic [LW-1:0] w_next_line;
    logic [CW:0]   w_col_len;
    logic [4:0]    w_back_mod;
    logic          w_rd_ok;
    logic [LW:0]   w_rd_sum;
    logic [HW:0]   w_hold_sum;
    logic [CW-1:0] w_hold_idx;

    function automatic logic blank_of(input logic [7:0] b);
        return (b <= 8'd32) || b[7];
    endfunction

    // Line base address; a small multiply by a constant.
    assign w_base = AW'(r_line) * AW'(LINE_CHARS);
    assign w_next_line = (r_line == LW'(LINES - 1)) ? '0 : r_line + 1'b1;

    // Read address for a read item: rows_back reduced modulo LINES by subtraction.
    always_comb begin
        w_back_mod = i_rows_back;
        for (int k = 0; k < 32 / LINES; k++) begin
            if (32'(w_back_mod) >= LINES)
                w_back_mod = w_back_mod - 5'(LINES);
        end
        w_rd_sum = {1'b0, r_line} + (LW+1)'(LINES) - (LW+1)'(w_back_mod);
        if (w_rd_sum >= (LW+1)'(LINES))
            w_rd_sum = w_rd_sum - (LW+1)'(LINES);
        w_rd_ok = (32'(i_read_column) < LINE_CHARS);
    end

    // Memory write port selection.
    always_comb begin
        w_we      = 1'b0;
        w_wr_addr = w_base + AW'(r_col);
        w_wr_data = r_byte;
        if (i_cmd.clr_step) begin
            w_we = 1'b1; w_wr_addr = r_clr_addr; w_wr_data = C_ZERO;
        end else if (i_cmd.blank_step) begin
            w_we = 1'b1; w_wr_addr = w_base + AW'(r_cnt); w_wr_data = C_SPACE;
        end else if (i_cmd.put_in) begin
            w_we = 1'b1;
        end else if (i_cmd.put_space) begin
            w_we = 1'b1; w_wr_data = C_SPACE;
        end else if (i_cmd.put_word) begin
            w_we = 1'b1; w_wr_data = r_wdata;
        end
    end

    assign w_rd_addr = i_cmd.cell_rd
        ? AW'(r_rd_line) * AW'(LINE_CHARS) + AW'(r_rd_col[CW-1:0])
        : w_base + AW'(r_col) - AW'(1);

    // Line store.
    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[w_wr_addr] <= w_wr_data;
        r_rdata <= r_mem[w_rd_addr];
    end

    // Held bytes form a ring that starts at r_head; new bytes go after the last one.
    assign w_hold_sum = {1'b0, r_head} + (HW+1)'(r_held);
    assign w_hold_idx = CW'((w_hold_sum >= (HW+1)'(LINE_CHARS))
                            ? w_hold_sum - (HW+1)'(LINE_CHARS) : w_hold_sum);

    // Word buffer with a registered read of the next head entry.
    always_ff @(posedge i_clk) begin
        if (i_cmd.hold_byte) r_word[w_hold_idx] <= r_byte;
        r_wdata <= r_word[n_head[CW-1:0]];
    end

    // Cursor, held count and sweep counters.
    always_comb begin
        n_line = r_line;
        n_col  = r_col;
        n_held = r_held;
        n_head = r_head;
        if (i_cmd.hold_byte) n_held = r_held + 1'b1;
        if (i_cmd.put_in || i_cmd.put_space || i_cmd.put_word)
            n_col = r_col + 1'b1;
        if (i_cmd.put_word) begin
            n_held = r_held - 1'b1;
            n_head = (r_head == HW'(LINE_CHARS - 1)) ? '0 : r_head + 1'b1;
        end
        if (i_cmd.new_line) begin
            n_line = w_next_line;
            n_col  = '0;
        end
        if (i_cmd.cr) n_col = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line     <= '0;
            r_col      <= '0;
            r_held     <= '0;
            r_head     <= '0;
            r_cnt      <= '0;
            r_clr_addr <= '0;
            r_clr_done <= 1'b0;
        end else begin
            r_line <= n_line;
            r_col  <= n_col;
            r_held <= n_held;
            r_head <= n_head;
            if (i_cmd.clr_step) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == AW'(DEPTH - 1)) r_clr_done <= 1'b1;
            end
            if (i_cmd.blank_step)
                r_cnt <= (r_cnt == CW'(LINE_CHARS - 1)) ? '0 : r_cnt + 1'b1;
        end
    end

    // Input capture.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mode    <= i_mode;
            r_byte    <= i_byte_in;
            r_eos     <= i_end_of_string;
            r_rd_line <= w_rd_sum[LW-1:0];
            r_rd_col  <= i_read_column;
            r_rd_ok   <= w_rd_ok;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.set_result) begin
            r_cell_byte <= (r_mode && r_rd_ok) ? r_rdata : 8'd0;
            r_line_out  <= 5'(r_line);
            r_col_out   <= 6'(r_col);
            r_held_out  <= 6'(r_held);
        end
    end

    assign w_col_len = {1'b0, r_col} + (CW+1)'(r_held);

    always_comb begin
        o_sts.clr_done    = r_clr_done;
        o_sts.blank_done  = (r_cnt == CW'(LINE_CHARS - 1));
        o_sts.mode        = r_mode;
        o_sts.in_blank    = blank_of(r_byte);
        o_sts.is_nl       = (r_byte == C_NEWLINE);
        o_sts.is_tab      = (r_byte == C_TAB);
        o_sts.is_cr       = (r_byte == C_CR);
        o_sts.eos         = r_eos;
        o_sts.prev_blank  = blank_of(r_rdata);
        o_sts.col_zero    = (r_col == '0);
        o_sts.held_any    = (r_held != '0);
        o_sts.held_full   = (r_held == HW'(LINE_CHARS));
        o_sts.wrap_needed = (r_held != HW'(LINE_CHARS)) &&
                            (32'(w_col_len) >= LINE_CHARS);
        o_sts.col_last    = (r_col == CW'(LINE_CHARS - 1));
        o_sts.tab_last    = ((r_col + 1'b1) & CW'(TAB_MASK)) == '0;
    end

    assign o_cell_byte  = r_cell_byte;
    assign o_line_now   = r_line_out;
    assign o_column_now = r_col_out;
    assign o_held_bytes = r_held_out;

endmodule

FILE: rtl/core/ctww_ctrl.sv
// Controller state machine that sequences each item through the datapath.
module ctww_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    output logic              o_valid,
    input  logic              i_stall,
    input  ctww_pkg::t_status i_sts,
    output ctww_pkg::t_cmd    o_cmd
);
    import ctww_pkg::*;

    t_state r_state, n_state;
    t_state r_ret, n_ret;       // state to resume after blanking a line
    logic   r_final, n_final;   // placement runs to the end of the word
    logic   r_after, n_after;   // input byte still to be handled after placement
    logic   r_ovalid, n_ovalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_ret    <= S_IDLE;
            r_final  <= 1'b0;
            r_after  <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ret    <= n_ret;
            r_final  <= n_final;
            r_after  <= n_after;
            r_ovalid <= n_ovalid;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_ret    = r_ret;
        n_final  = r_final;
        n_after  = r_after;
        n_ovalid = r_ovalid && i_stall;
        o_cmd    = '0;
        o_stall  = 1'b1;
        case (r_state)
            // Zero the line store after reset.
            S_CLEAR: begin
                if (i_sts.clr_done) n_state = S_IDLE;
                else o_cmd.clr_step = 1'b1;
            end
            S_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (i_sts.mode) begin
                    o_cmd.cell_rd = 1'b1;
                    n_state = S_READ;
                end else if (i_sts.in_blank) begin
                    n_after = 1'b1;
                    if (i_sts.held_any) begin
                        n_final = 1'b1;
                        n_state = i_sts.wrap_needed ? S_WRAP_NL : S_PLACE;
                    end else begin
                        n_state = S_EOS;
                    end
                end else if (i_sts.held_any || i_sts.col_zero) begin
                    o_cmd.hold_byte = 1'b1;
                    n_after = 1'b0;
                    n_state = S_EOS;
                end else begin
                    o_cmd.prev_rd = 1'b1;
                    n_state = S_PREV;
                end
            end
            S_PREV: begin
                n_after = 1'b0;
                if (i_sts.prev_blank) o_cmd.hold_byte = 1'b1;
                else o_cmd.put_in = 1'b1;
                n_state = S_EOS;
                if (!i_sts.prev_blank && i_sts.col_last) begin
                    o_cmd.new_line = 1'b1;
                    n_ret = S_EOS;
                    n_state = S_BLANKLINE;
                end
            end
            // Keep the addressed cell on the read port until the result can load.
            S_READ: begin
                o_cmd.cell_rd = 1'b1;
                if (!r_ovalid || !i_stall) begin
                    o_cmd.set_result = 1'b1;
                    n_state = S_DONE;
                end
            end
            S_WRAP_NL: begin
                o_cmd.new_line = 1'b1;
                n_ret = S_PLACE;
                n_state = S_BLANKLINE;
            end
            // Place held bytes one per cycle, pausing to blank each started line.
            S_PLACE: begin
                if (!i_sts.held_any) begin
                    n_state = S_EOS;
                end else begin
                    o_cmd.put_word = 1'b1;
                    if (i_sts.col_last) begin
                        o_cmd.new_line = 1'b1;
                        n_ret = r_final ? S_PLACE : S_EOS;
                        n_state = S_BLANKLINE;
                    end
                end
            end
            S_BLANKLINE: begin
                o_cmd.blank_step = 1'b1;
                if (i_sts.blank_done) n_state = r_ret;
            end
            // A tab that reaches the line end stops at column zero of the new line.
            S_TAB: begin
                o_cmd.put_space = 1'b1;
                if (i_sts.col_last) begin
                    o_cmd.new_line = 1'b1;
                    n_ret = S_EOS;
                    n_state = S_BLANKLINE;
                end else if (i_sts.tab_last) begin
                    n_state = S_EOS;
                end
            end
            // Handle the blank byte, then full-word and end-of-string checks, then load the result.
            S_EOS: begin
                if (r_after) begin
                    n_after = 1'b0;
                    if (i_sts.is_nl) begin
                        o_cmd.new_line = 1'b1;
                        n_ret = S_EOS;
                        n_state = S_BLANKLINE;
                    end else if (i_sts.is_tab) begin
                        n_state = S_TAB;
                    end else if (i_sts.is_cr) begin
                        o_cmd.cr = 1'b1;
                    end else begin
                        o_cmd.put_in = 1'b1;
                        if (i_sts.col_last) begin
                            o_cmd.new_line = 1'b1;
                            n_ret = S_EOS;
                            n_state = S_BLANKLINE;
                        end
                    end
                end else if (i_sts.held_full) begin
                    n_final = 1'b0;
                    n_state = S_PLACE;
                end else if (i_sts.eos && i_sts.held_any) begin
                    n_final = 1'b1;
                    n_state = i_sts.wrap_needed ? S_WRAP_NL : S_PLACE;
                end else if (!r_ovalid || !i_stall) begin
                    o_cmd.set_result = 1'b1;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                n_ovalid = 1'b1;
                n_state  = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_valid = r_ovalid;

endmodule

FILE: rtl/core/console_text_wrap_writer_core.sv
// Top level of the console text wrap writer.
// The result waits on every step of its item: each tab blank, each placed held byte, and
// the blanking of all LINE_CHARS cells of each started line (a held word that wraps
// starts its new line before placing).
// Throughput: one item at a time; the next item is taken only after the result is loaded.
// Reset: synchronous active-low; a sweep zeroes the store while input is stalled.
module console_text_wrap_writer_core #(
    parameter int LINE_CHARS = 40,
    parameter int LINES      = 25
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic       i_mode,
    input  logic [7:0] i_byte_in,
    input  logic       i_end_of_string,
    input  logic [4:0] i_rows_back,
    input  logic [5:0] i_read_column,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_cell_byte,
    output logic [4:0] o_line_now,
    output logic [5:0] o_column_now,
    output logic [5:0] o_held_bytes
);
    import ctww_pkg::*;

    t_cmd    w_cmd;
    t_status w_sts;

    ctww_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .o_valid, .i_stall,
        .i_sts(w_sts), .o_cmd(w_cmd)
    );

    ctww_datapath #(.LINE_CHARS(LINE_CHARS), .LINES(LINES)) u_dp (
        .i_clk, .i_rst_n, .i_cmd(w_cmd), .o_sts(w_sts),
        .i_mode, .i_byte_in, .i_end_of_string, .i_rows_back, .i_read_column,
        .o_cell_byte, .o_line_now, .o_column_now, .o_held_bytes
    );

endmodule

FILE: rtl/core/ctww_checker.sv
// Port-level checker for the console text wrap writer.
module ctww_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_stall,
    input logic       o_valid,
    input logic       i_stall,
    input logic [7:0] o_cell_byte,
    input logic [4:0] o_line_now,
    input logic [5:0] o_column_now,
    input logic [5:0] o_held_bytes
);
    // A stalled result item holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_cell_byte) && $stable(o_line_now))
        else $error("result changed under stall");

    // Reported cursor stays in range.
    a_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_column_now < 6'd40 && o_line_now < 5'd25 && o_held_bytes <= 6'd40)
        else $error("cursor out of range");

    // An accepted input item stalls the input in the cycle after it.
    a_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("back-to-back accept");

endmodule

bind console_text_wrap_writer_core ctww_checker u_chk (.*);

FILE: sim/tb_console_text_wrap_writer_core.sv
// Self-checking testbench for the console text wrap writer core.
module tb_console_text_wrap_writer_core;
    timeunit 1ns;
    timeprecision 1ps;
    import ctww_pkg::*;

    localparam int LINE_CHARS = 40;
    localparam int LINES = 25;
    localparam int CYCLE_LIMIT = 900000;

    typedef struct packed {
        logic       mode;
        logic [7:0] byte_in;
        logic       eos;
        logic [4:0] rows_back;
        logic [5:0] read_column;
    } t_item;

    typedef struct packed {
        logic [7:0] cell_byte;
        logic [4:0] line_now;
        logic [5:0] column_now;
        logic [5:0] held_bytes;
    } t_result;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_stall;
    logic       i_mode = 1'b0;
    logic [7:0] i_byte_in = '0;
    logic       i_end_of_string = 1'b0;
    logic [4:0] i_rows_back = '0;
    logic [5:0] i_read_column = '0;
    logic       o_valid;
    logic       i_stall = 1'b0;
    logic [7:0] o_cell_byte;
    logic [4:0] o_line_now;
    logic [5:0] o_column_now;
    logic [5:0] o_held_bytes;

    console_text_wrap_writer_core #(.LINE_CHARS(LINE_CHARS), .LINES(LINES)) i_dut (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Predictor state of the console.
    logic [7:0] screen [LINES*LINE_CHARS];
    logic [7:0] word_hold [LINE_CHARS];
    int cur_line, cur_col, hold_count;

    t_item   pending_items[$];
    t_result expected_results[$];
    int errors = 0, cycles = 0, accepted = 0, checked = 0, reads_seen = 0;
    bit quiet_phase = 1'b0;

    function automatic bit blank_byte(logic [7:0] b);
        return b <= 8'd32 || b >= 8'd128;
    endfunction

    function automatic void start_line();
        cur_col = 0;
        cur_line = (cur_line + 1) % LINES;
        for (int i = 0; i < LINE_CHARS; i++) screen[cur_line*LINE_CHARS + i] = C_SPACE;
    endfunction

    function automatic void store_cell(logic [7:0] c);
        screen[cur_line*LINE_CHARS + cur_col] = c;
        cur_col++;
        if (cur_col >= LINE_CHARS) start_line();
    endfunction

    // Place held word bytes; an unended full-line word stops at the line end.
    function automatic void flush_word(bit ended);
        int len, n;
        len = hold_count >= LINE_CHARS ? LINE_CHARS : hold_count;
        n = 0;
        if (len != LINE_CHARS && cur_col + len >= LINE_CHARS) start_line();
        while (n < hold_count) begin
            store_cell(word_hold[n]);
            n++;
            if (!ended && cur_col == 0) break;
        end
        for (int i = 0; i < hold_count - n; i++) word_hold[i] = word_hold[i+n];
        hold_count -= n;
    endfunction

    function automatic t_result console_step(t_item it);
        t_result r;
        int ln;
        r = '0;
        if (it.mode) begin
            ln = (cur_line + LINES - (it.rows_back % LINES)) % LINES;
            if (it.read_column < LINE_CHARS)
                r.cell_byte = screen[ln*LINE_CHARS + it.read_column];
        end else begin
            if (!blank_byte(it.byte_in)) begin
                if (hold_count > 0 || cur_col == 0 ||
                    blank_byte(screen[cur_line*LINE_CHARS + cur_col - 1])) begin
                    if (hold_count < LINE_CHARS) word_hold[hold_count++] = it.byte_in;
                    if (hold_count >= LINE_CHARS) flush_word(1'b0);
                end else begin
                    store_cell(it.byte_in);
                end
            end else begin
                if (hold_count > 0) flush_word(1'b1);
                if (it.byte_in == C_NEWLINE) start_line();
                else if (it.byte_in == C_TAB) begin
                    do store_cell(C_SPACE); while ((cur_col & TAB_MASK) != 0);
                end else if (it.byte_in == C_CR) cur_col = 0;
                else store_cell(it.byte_in);
            end
            if (it.eos && hold_count > 0) flush_word(1'b1);
        end
        r.line_now = cur_line[4:0];
        r.column_now = cur_col[5:0];
        r.held_bytes = hold_count[5:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch at result %0d: %s got %0d expected %0d", checked, what, got, want);
        errors++;
    endtask

    function automatic void add_print(logic [7:0] b, bit eos);
        t_item it;
        it = '0;
        it.byte_in = b;
        it.eos = eos;
        pending_items.push_back(it);
    endfunction

    function automatic void add_read(int back, int col);
        t_item it;
        it = '0;
        it.mode = 1'b1;
        it.rows_back = back[4:0];
        it.read_column = col[5:0];
        it.byte_in = 8'($urandom);
        it.eos = 1'($urandom);
        pending_items.push_back(it);
    endfunction

    function automatic logic [7:0] word_char();
        return 8'($urandom_range(33, 127));
    endfunction

    // Driver: presents queued items, idling at random, and stalls the output at random.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n) begin
            if (!(i_valid && o_stall)) begin
                if (i_valid) begin
                    expected_results.push_back(console_step({i_mode, i_byte_in,
                        i_end_of_string, i_rows_back, i_read_column}));
                    accepted <= accepted + 1;
                end
                if (pending_items.size() > 0 && (quiet_phase || $urandom_range(99) >= 17)) begin
                    t_item it;
                    it = pending_items.pop_front();
                    i_valid <= 1'b1;
                    i_mode <= it.mode;
                    i_byte_in <= it.byte_in;
                    i_end_of_string <= it.eos;
                    i_rows_back <= it.rows_back;
                    i_read_column <= it.read_column;
                end else begin
                    i_valid <= 1'b0;
                end
            end
            i_stall <= quiet_phase ? 1'b0 : ($urandom_range(99) < 17);
        end
    end

    // Monitor: compares each accepted result with the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_results.size() == 0) begin
                $display("unexpected result with nothing predicted");
                errors++;
            end else begin
                t_result w;
                w = expected_results.pop_front();
                if (o_cell_byte !== w.cell_byte) report_mismatch("cell_byte", o_cell_byte, w.cell_byte);
                if (o_line_now !== w.line_now) report_mismatch("line_now", o_line_now, w.line_now);
                if (o_column_now !== w.column_now)
                    report_mismatch("column_now", o_column_now, w.column_now);
                if (o_held_bytes !== w.held_bytes)
                    report_mismatch("held_bytes", o_held_bytes, w.held_bytes);
                checked++;
            end
        end
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb_console_text_wrap_writer_core NOT OK");
            $finish;
        end
    end

    initial begin
        int total, k, n;
        for (int i = 0; i < LINES*LINE_CHARS; i++) screen[i] = 8'h00;
        for (int i = 0; i < LINE_CHARS; i++) word_hold[i] = 8'h00;
        cur_line = 0; cur_col = 0; hold_count = 0;

        // Directed: unwritten cells, column overflow, special bytes, then wraps.
        add_read(0, 0);
        add_read(24, 39);
        add_read(3, 63);
        add_print(8'h41, 0); add_print(8'h42, 0); add_print(C_SPACE, 0);
        add_print(8'h7F, 0); add_print(8'h21, 1);
        add_print(C_TAB, 0); add_print(8'hFF, 0); add_print(8'h80, 0);
        add_print(C_ZERO, 0); add_print(8'h43, 0); add_print(C_CR, 0);
        add_print(8'h44, 1); add_print(C_NEWLINE, 0);
        for (int i = 0; i < 37; i++) add_print(C_SPACE, 0);
        add_print(C_TAB, 0);
        add_print(C_CR, 0);
        for (int i = 0; i < 38; i++) add_print(8'h2E, 0);
        add_print(C_SPACE, 0);
        for (int i = 0; i < 45; i++) add_print(word_char(), 0);
        add_print(C_SPACE, 1);
        add_read(1, 5); add_read(0, 0);

        // Random: words of random length, delimiters, string ends, reads.
        total = pending_items.size();
        while (total < 1800) begin
            k = $urandom_range(99);
            if (k < 55) begin
                n = ($urandom_range(9) == 0) ? $urandom_range(30, 50) : $urandom_range(1, 10);
                for (int i = 0; i < n; i++) add_print(word_char(), (i == n-1) && $urandom_range(5) == 0);
                total += n;
            end else if (k < 75) begin
                add_print(C_SPACE, $urandom_range(7) == 0);
                total++;
            end else if (k < 82) begin
                case ($urandom_range(2))
                    0: add_print(C_NEWLINE, 1'($urandom));
                    1: add_print(C_TAB, 1'($urandom));
                    default: add_print(C_CR, 1'($urandom));
                endcase
                total++;
            end else if (k < 87) begin
                add_print(8'($urandom), 1'($urandom));
                total++;
            end else begin
                add_read($urandom_range(31), $urandom_range(63));
                total++;
            end
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // A quiet stretch with no idling part way through.
        wait (accepted >= 700);
        quiet_phase = 1'b1;
        wait (accepted >= 1000);
        quiet_phase = 1'b0;
        wait (pending_items.size() == 0 && !i_valid);
        wait (expected_results.size() == 0);
        repeat (200) @(posedge i_clk);
        $display("Checked %0d results over %0d items: text, words, tabs, wraps and reads.",
                 checked, accepted);
        if (errors == 0) begin
            $display("tb_console_text_wrap_writer_core OK");
        end else begin
            $display("tb_console_text_wrap_writer_core NOT OK");
        end
        $finish;
    end
endmodule

FILE: console_text_wrap_writer_core.f
rtl/core/ctww_pkg.sv
rtl/core/ctww_datapath.sv
rtl/core/ctww_ctrl.sv
rtl/core/console_text_wrap_writer_core.sv
rtl/core/ctww_checker.sv
sim/tb_console_text_wrap_writer_core.sv
